// ===== hw/rtl/sqmm_pkg.sv =====
// Shared types and constants for the square matrix multiply block.
`timescale 1ns / 1ps

package sqmm_pkg;

  localparam int DIM_DEFAULT = 32;
  localparam int QUEUE_DEPTH = 4;

  localparam int ACT_W  = 2;
  localparam int IDX_W  = 5;
  localparam int DATA_W = 32;
  localparam int SIZE_W = 6;

  localparam logic [ACT_W-1:0] ACT_WRITE_A = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WRITE_B = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ    = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

  typedef enum logic [1:0] {
    OP_WRITE_A,
    OP_WRITE_B,
    OP_READ,
    OP_READ_ZERO
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [DATA_W-1:0] value;
    logic [SIZE_W-1:0] size;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

  typedef struct packed {
    logic reading;
    logic idle;
  } back_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ISSUE,
    BK_DRAIN
  } back_state_t;

endpackage

// ===== hw/rtl/sqmm_front.sv =====
// Front end: size register, command acceptance and classification.
`timescale 1ns / 1ps

module sqmm_front #(
  parameter int DIM = sqmm_pkg::DIM_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sqmm_pkg::SIZE_W-1:0]   cfg_matrix_size,
  input  logic                          start,
  input  logic [sqmm_pkg::ACT_W-1:0]    in_action,
  input  logic [sqmm_pkg::IDX_W-1:0]    in_row,
  input  logic [sqmm_pkg::IDX_W-1:0]    in_col,
  input  logic [sqmm_pkg::DATA_W-1:0]   in_value,
  input  logic                          q_full,
  output logic                          busy,
  output logic                          push,
  output sqmm_pkg::cmd_t                push_cmd
);

  localparam int SizeCap = (DIM < 63) ? DIM : 63;

  logic [sqmm_pkg::SIZE_W-1:0] size_r;
  logic [sqmm_pkg::SIZE_W-1:0] eff_size;
  logic                        in_store;
  logic                        in_window;
  logic                        keep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= sqmm_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      size_r <= cfg_matrix_size;
    end
  end

  always_comb begin
    eff_size  = (size_r > 6'(SizeCap)) ? 6'(SizeCap) : size_r;
    in_store  = (32'(in_row) < 32'(DIM)) && (32'(in_col) < 32'(DIM));
    in_window = (6'(in_row) < eff_size) && (6'(in_col) < eff_size);
    keep      = 1'b0;
    push_cmd.op    = sqmm_pkg::OP_READ_ZERO;
    push_cmd.row   = in_row;
    push_cmd.col   = in_col;
    push_cmd.value = in_value;
    push_cmd.size  = eff_size;
    case (in_action)
      sqmm_pkg::ACT_WRITE_A: begin
        push_cmd.op = sqmm_pkg::OP_WRITE_A;
        keep        = in_store;
      end
      sqmm_pkg::ACT_WRITE_B: begin
        push_cmd.op = sqmm_pkg::OP_WRITE_B;
        keep        = in_store;
      end
      sqmm_pkg::ACT_READ: begin
        push_cmd.op = in_window ? sqmm_pkg::OP_READ : sqmm_pkg::OP_READ_ZERO;
        keep        = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign busy = q_full;
  assign push = start && !q_full && keep;

endmodule

// ===== hw/rtl/sqmm_queue.sv =====
// Small command queue between the front end and the back end.
`timescale 1ns / 1ps

module sqmm_queue #(
  parameter int DEPTH = sqmm_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  sqmm_pkg::cmd_t                push_cmd,
  input  logic                          pop,
  output sqmm_pkg::queue_head_t         head,
  output logic                          full,
  output logic [$clog2(DEPTH+1)-1:0]    level
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  sqmm_pkg::cmd_t  slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [LW-1:0]   count_r;
  logic            do_pop;

  assign do_pop = pop && (count_r != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (32'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (32'(rd_ptr_r) == DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign head.valid = (count_r != '0);
  assign head.cmd   = slot_r[rd_ptr_r];
  assign full       = (count_r == LW'(DEPTH));
  assign level      = count_r;

endmodule

// ===== hw/rtl/sqmm_back.sv =====
// Back end: matrix stores, multiply-accumulate pipeline and result register.
`timescale 1ns / 1ps

module sqmm_back #(
  parameter int DIM = sqmm_pkg::DIM_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sqmm_pkg::queue_head_t         head,
  output logic                          pop,
  output sqmm_pkg::back_status_t        status,
  output logic                          out_valid,
  output logic [sqmm_pkg::IDX_W-1:0]    out_row,
  output logic [sqmm_pkg::IDX_W-1:0]    out_col,
  output logic [sqmm_pkg::DATA_W-1:0]   out_value
);

  localparam int AW    = $clog2(DIM * DIM);
  localparam int WORDS = DIM * DIM;

  sqmm_pkg::back_state_t state_r, state_nxt;

  logic [sqmm_pkg::DATA_W-1:0] left_mem_r  [WORDS];
  logic [sqmm_pkg::DATA_W-1:0] right_mem_r [WORDS];

  logic [AW-1:0]               wr_addr;
  logic [AW-1:0]               a_addr_r;
  logic [AW-1:0]               b_addr_r;
  logic [sqmm_pkg::SIZE_W-1:0] k_r;
  logic [sqmm_pkg::SIZE_W-1:0] n_r;
  logic                        issue;
  logic                        issue_last;
  logic                        v1_r, last1_r;
  logic                        v2_r, last2_r;
  logic [sqmm_pkg::DATA_W-1:0] a_q_r, b_q_r;
  logic [sqmm_pkg::DATA_W-1:0] prod_r;
  logic [sqmm_pkg::DATA_W-1:0] acc_r;
  logic [sqmm_pkg::DATA_W-1:0] acc_sum;
  logic                        out_valid_r;
  logic [sqmm_pkg::IDX_W-1:0]  row_r, col_r;
  logic [sqmm_pkg::DATA_W-1:0] out_value_r;
  logic                        pop_wr_a, pop_wr_b, pop_rd, pop_zero;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sqmm_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    pop        = 1'b0;
    issue      = 1'b0;
    issue_last = 1'b0;
    case (state_r)
      sqmm_pkg::BK_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          if (head.cmd.op == sqmm_pkg::OP_READ) begin
            state_nxt = sqmm_pkg::BK_ISSUE;
          end
        end
      end
      sqmm_pkg::BK_ISSUE: begin
        issue      = 1'b1;
        issue_last = (k_r == n_r - 1'b1);
        if (issue_last) begin
          state_nxt = sqmm_pkg::BK_DRAIN;
        end
      end
      sqmm_pkg::BK_DRAIN: begin
        if (v2_r && last2_r) begin
          state_nxt = sqmm_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = sqmm_pkg::BK_IDLE;
      end
    endcase
  end

  assign pop_wr_a = pop && (head.cmd.op == sqmm_pkg::OP_WRITE_A);
  assign pop_wr_b = pop && (head.cmd.op == sqmm_pkg::OP_WRITE_B);
  assign pop_rd   = pop && (head.cmd.op == sqmm_pkg::OP_READ);
  assign pop_zero = pop && (head.cmd.op == sqmm_pkg::OP_READ_ZERO);
  assign wr_addr  = AW'(head.cmd.row) * AW'(DIM) + AW'(head.cmd.col);
  assign acc_sum  = acc_r + prod_r;

  always_ff @(posedge clk) begin
    if (pop_wr_a) begin
      left_mem_r[wr_addr] <= head.cmd.value;
    end
    if (issue) begin
      a_q_r <= left_mem_r[a_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (pop_wr_b) begin
      right_mem_r[wr_addr] <= head.cmd.value;
    end
    if (issue) begin
      b_q_r <= right_mem_r[b_addr_r];
    end
  end

  // addresses walk row r of A and column c of B
  always_ff @(posedge clk) begin
    if (pop_rd) begin
      a_addr_r <= AW'(head.cmd.row) * AW'(DIM);
      b_addr_r <= AW'(head.cmd.col);
      k_r      <= '0;
      n_r      <= head.cmd.size;
    end else if (issue) begin
      a_addr_r <= a_addr_r + 1'b1;
      b_addr_r <= b_addr_r + AW'(DIM);
      k_r      <= k_r + 1'b1;
    end
    if (v1_r) begin
      prod_r <= 32'(a_q_r * b_q_r);
    end
    if (pop_rd) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_sum;
    end
    if (pop) begin
      row_r <= head.cmd.row;
      col_r <= head.cmd.col;
    end
    if (pop_zero) begin
      out_value_r <= '0;
    end else if (v2_r && last2_r) begin
      out_value_r <= acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      last1_r     <= 1'b0;
      v2_r        <= 1'b0;
      last2_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= issue;
      last1_r     <= issue_last;
      v2_r        <= v1_r;
      last2_r     <= last1_r;
      out_valid_r <= pop_zero || (v2_r && last2_r);
    end
  end

  assign status.reading = (state_r != sqmm_pkg::BK_IDLE);
  assign status.idle    = (state_r == sqmm_pkg::BK_IDLE);

  assign out_valid = out_valid_r;
  assign out_row   = row_r;
  assign out_col   = col_r;
  assign out_value = out_value_r;

endmodule

// ===== hw/rtl/square_matrix_multiply.sv =====
// Top level of the square integer matrix multiply block.
`timescale 1ns / 1ps

// Usage:
//   Command channel: an item is taken at a clock edge with start high and busy
//   low. Action write A / write B stores in_value at (in_row, in_col); a read
//   returns element (in_row, in_col) of A x B, wrapped to 32 bits. Action 3
//   and writes outside the store are dropped without a result.
//   Result channel: out_valid is high for one cycle per read, with out_row,
//   out_col and out_product_value; the receiver always takes the beat.
//   Config: cfg_we loads cfg_matrix_size (n, clamped to DIM); write it idle.
//   Flow: commands pass through a four-entry queue to the back end. A write
//   is stored as the back end pops it. A read inside n x n holds the back end
//   and steps one element pair per cycle through one multiply-accumulate unit
//   fed by the two single-port stores. A read outside n x n returns 0 the
//   cycle after it is popped. busy is high while the queue is full.
//   Reset: queue emptied, n set to 32, matrix stores keep undefined contents.
module square_matrix_multiply #(
  parameter int DIM = sqmm_pkg::DIM_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [sqmm_pkg::SIZE_W-1:0]        cfg_matrix_size,
  input  logic                               start,
  output logic                               busy,
  input  logic [sqmm_pkg::ACT_W-1:0]         in_action,
  input  logic [sqmm_pkg::IDX_W-1:0]         in_row,
  input  logic [sqmm_pkg::IDX_W-1:0]         in_col,
  input  logic signed [sqmm_pkg::DATA_W-1:0] in_value,
  output logic                               out_valid,
  output logic [sqmm_pkg::IDX_W-1:0]         out_row,
  output logic [sqmm_pkg::IDX_W-1:0]         out_col,
  output logic signed [sqmm_pkg::DATA_W-1:0] out_product_value
);

  localparam int QD = sqmm_pkg::QUEUE_DEPTH;

  sqmm_pkg::cmd_t                push_cmd;
  sqmm_pkg::queue_head_t         head;
  sqmm_pkg::back_status_t        back_status;
  logic                          push;
  logic                          pop;
  logic                          q_full;
  logic [$clog2(QD+1)-1:0]       q_level;
  logic [sqmm_pkg::DATA_W-1:0]   result_value;

  sqmm_front #(
    .DIM (DIM)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_matrix_size (cfg_matrix_size),
    .start           (start),
    .in_action       (in_action),
    .in_row          (in_row),
    .in_col          (in_col),
    .in_value        (in_value),
    .q_full          (q_full),
    .busy            (busy),
    .push            (push),
    .push_cmd        (push_cmd)
  );

  sqmm_queue #(
    .DEPTH (QD)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .level    (q_level)
  );

  sqmm_back #(
    .DIM (DIM)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .status    (back_status),
    .out_valid (out_valid),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (result_value)
  );

  assign out_product_value = result_value;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_level <= ($clog2(QD+1))'(QD))
    else $error("queue level above depth");

  a_no_pop_while_reading: assert property (@(posedge clk) disable iff (!rst_n)
    !back_status.idle |-> !pop)
    else $error("queue popped while back end busy");

  a_busy_is_full: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (q_level == ($clog2(QD+1))'(QD)))
    else $error("busy without full queue");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the square matrix multiply block.
`timescale 1ns / 1ps

module testbench;
  import sqmm_pkg::*;

  localparam int TB_DIM        = DIM_DEFAULT;
  localparam int RANDOM_ITEMS  = 1500;
  localparam int SETTLE_CYCLES = 48;
  localparam int IDLE_LIMIT    = 4000;
  localparam int REPORT_LIMIT  = 10;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  typedef enum logic {STIM_ITEM, STIM_SIZE} stim_kind_t;

  typedef struct {
    stim_kind_t        kind;
    logic [ACT_W-1:0]  action;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [DATA_W-1:0] value;
    bit                fixed;
    logic [DATA_W-1:0] product;
  } stim_row_t;

  typedef struct packed {
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [DATA_W-1:0] value;
  } product_beat_t;

  // size rows carry the new matrix size in the value column
  stim_row_t directed_rows [26] = '{
    '{STIM_SIZE, ACT_READ,    5'd0,  5'd0,  32'd0,        1'b0, 32'd0},
    '{STIM_ITEM, ACT_READ,    5'd0,  5'd0,  32'd0,        1'b1, 32'd0},
    '{STIM_ITEM, ACT_READ,    5'd31, 5'd31, 32'hFFFFFFFF, 1'b1, 32'd0},
    '{STIM_ITEM, ACT_UNUSED,  5'd31, 5'd31, 32'hFFFFFFFF, 1'b0, 32'd0},
    '{STIM_SIZE, ACT_READ,    5'd0,  5'd0,  32'd1,        1'b0, 32'd0},
    '{STIM_ITEM, ACT_WRITE_A, 5'd0,  5'd0,  32'h80000000, 1'b0, 32'd0},
    '{STIM_ITEM, ACT_WRITE_B, 5'd0,  5'd0,  32'h80000000, 1'b0, 32'd0},
    '{STIM_ITEM, ACT_READ,    5'd0,  5'd0,  32'd0,        1'b1, 32'd0},
    '{STIM_ITEM, ACT_READ,    5'd0,  5'd1,  32'd0,        1'b1, 32'd0},
    '{STIM_ITEM, ACT_READ,    5'd31, 5'd31, 32'd0,        1'b1, 32'd0},
    '{STIM_ITEM, ACT_WRITE_A, 5'd0,  5'd0,  32'h7FFFFFFF, 1'b0, 32'd0},
    '{STIM_ITEM, ACT_WRITE_B, 5'd0,  5'd0,  32'h7FFFFFFF, 1'b0, 32'd0},
    '{STIM_ITEM, ACT_READ,    5'd0,  5'd0,  32'd0,        1'b1, 32'd1},
    '{STIM_ITEM, ACT_WRITE_A, 5'd0,  5'd0,  32'hFFFFFFFF, 1'b0, 32'd0},
    '{STIM_ITEM, ACT_WRITE_B, 5'd0,  5'd0,  32'hFFFFFFFF, 1'b0, 32'd0},
    '{STIM_ITEM, ACT_READ,    5'd0,  5'd0,  32'd0,        1'b1, 32'd1},
    '{STIM_SIZE, ACT_READ,    5'd0,  5'd0,  32'd2,        1'b0, 32'd0},
    '{STIM_ITEM, ACT_WRITE_A, 5'd0,  5'd0,  32'd1,        1'b0, 32'd0},
    '{STIM_ITEM, ACT_WRITE_A, 5'd0,  5'd1,  32'd2,        1'b0, 32'd0},
    '{STIM_ITEM, ACT_WRITE_B, 5'd0,  5'd0,  32'd3,        1'b0, 32'd0},
    '{STIM_ITEM, ACT_WRITE_B, 5'd1,  5'd0,  32'd4,        1'b0, 32'd0},
    '{STIM_ITEM, ACT_WRITE_A, 5'd0,  5'd2,  32'h12345678, 1'b0, 32'd0},
    '{STIM_ITEM, ACT_READ,    5'd0,  5'd0,  32'd0,        1'b1, 32'd11},
    '{STIM_ITEM, ACT_READ,    5'd2,  5'd0,  32'd0,        1'b1, 32'd0},
    '{STIM_ITEM, ACT_WRITE_A, 5'd0,  5'd0,  32'hFFFFFFFF, 1'b0, 32'd0},
    '{STIM_ITEM, ACT_READ,    5'd0,  5'd0,  32'hA5A5A5A5, 1'b0, 32'd0}
  };

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [SIZE_W-1:0]         cfg_matrix_size;
  logic                      start;
  logic                      busy;
  logic [ACT_W-1:0]          in_action;
  logic [IDX_W-1:0]          in_row;
  logic [IDX_W-1:0]          in_col;
  logic signed [DATA_W-1:0]  in_value;
  logic                      out_valid;
  logic [IDX_W-1:0]          out_row;
  logic [IDX_W-1:0]          out_col;
  logic signed [DATA_W-1:0]  out_product_value;

  logic [DATA_W-1:0] left_store  [TB_DIM*TB_DIM];
  logic [DATA_W-1:0] right_store [TB_DIM*TB_DIM];
  logic [SIZE_W-1:0] active_size;
  product_beat_t     pending_products [$];
  int                mismatch_count;
  int                commands_sent;
  int                idle_cycles;
  bit                steady_stream;

  square_matrix_multiply #(.DIM(TB_DIM)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_matrix_size   (cfg_matrix_size),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_row            (in_row),
    .in_col            (in_col),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_product_value (out_product_value)
  );

  always #2 clk = ~clk;

  function automatic int used_size();
    return (active_size > TB_DIM) ? TB_DIM : int'(active_size);
  endfunction

  function automatic logic [DATA_W-1:0] expected_product(int r, int c);
    logic [DATA_W-1:0] acc;
    int n;
    acc = '0;
    n = used_size();
    if (r < n && c < n) begin
      for (int k = 0; k < n; k++) begin
        acc = acc + left_store[r*TB_DIM + k] * right_store[k*TB_DIM + c];
      end
    end
    return acc;
  endfunction

  function automatic int gap_len();
    int pick;
    if (steady_stream) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 15))
      0: return 32'h00000000;
      1: return 32'h00000001;
      2: return 32'hFFFFFFFF;
      3: return 32'h7FFFFFFF;
      4: return 32'h80000000;
      default: return $urandom;
    endcase
  endfunction

  task automatic note_mismatch(input string msg);
    if (mismatch_count < REPORT_LIMIT) $display("%s", msg);
    mismatch_count++;
  endtask

  task automatic issue_command(input logic [ACT_W-1:0] act, input int r, input int c,
                               input logic [DATA_W-1:0] v, input bit fixed,
                               input logic [DATA_W-1:0] fixed_val);
    int gap;
    product_beat_t beat;
    @(negedge clk);
    start     <= 1'b1;
    in_action <= act;
    in_row    <= r[IDX_W-1:0];
    in_col    <= c[IDX_W-1:0];
    in_value  <= v;
    do @(posedge clk); while (busy);
    case (act)
      ACT_WRITE_A: left_store[r*TB_DIM + c] = v;
      ACT_WRITE_B: right_store[r*TB_DIM + c] = v;
      ACT_READ: begin
        beat.row   = r[IDX_W-1:0];
        beat.col   = c[IDX_W-1:0];
        beat.value = fixed ? fixed_val : expected_product(r, c);
        pending_products.push_back(beat);
      end
      default: ;
    endcase
    if (act != ACT_UNUSED) commands_sent++;
    gap = gap_len();
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain_and_resize(input logic [SIZE_W-1:0] new_size);
    @(negedge clk);
    start <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we          <= 1'b1;
    cfg_matrix_size <= new_size;
    active_size      = new_size;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic issue_noise();
    if ($urandom_range(0, 1) == 0) begin
      issue_command(ACT_UNUSED, $urandom_range(0, 31), $urandom_range(0, 31), $urandom, 0, '0);
    end else begin
      issue_command($urandom_range(0, 1) ? ACT_WRITE_B : ACT_WRITE_A,
                    $urandom_range(0, 31), $urandom_range(0, 31), rand_value(), 0, '0);
    end
  endtask

  task automatic issue_write(input logic [ACT_W-1:0] act, input int r, input int c);
    if ($urandom_range(0, 11) == 0) issue_noise();
    issue_command(act, r, c, rand_value(), 0, '0);
  endtask

  // one load of rows of A and columns of B, then mostly reads of it
  task automatic run_phase(input logic [SIZE_W-1:0] size_val);
    int n;
    int rows [$];
    int cols [$];
    int reads;
    int r;
    int c;
    drain_and_resize(size_val);
    steady_stream = ($urandom_range(0, 3) == 0);
    n = used_size();
    if (n <= 8) begin
      for (int i = 0; i < n; i++) begin
        rows.push_back(i);
        cols.push_back(i);
      end
    end else begin
      repeat ($urandom_range(1, 4)) rows.push_back($urandom_range(0, n - 1));
      repeat ($urandom_range(1, 4)) cols.push_back($urandom_range(0, n - 1));
    end
    foreach (rows[i]) for (int k = 0; k < n; k++) issue_write(ACT_WRITE_A, rows[i], k);
    foreach (cols[i]) for (int k = 0; k < n; k++) issue_write(ACT_WRITE_B, k, cols[i]);
    reads = $urandom_range(3, 3 * n + 6);
    repeat (reads) begin
      case ($urandom_range(0, 9))
        0: begin
          if (n < TB_DIM) begin
            r = $urandom_range(n, 31);
            c = $urandom_range(0, 31);
            if ($urandom_range(0, 1)) begin
              int t;
              t = r;
              r = c;
              c = t;
            end
          end else begin
            r = rows[$urandom_range(0, rows.size() - 1)];
            c = cols[$urandom_range(0, cols.size() - 1)];
          end
          issue_command(ACT_READ, r, c, $urandom, 0, '0);
        end
        1: issue_command($urandom_range(0, 1) ? ACT_WRITE_B : ACT_WRITE_A,
                         $urandom_range(0, 31), $urandom_range(0, 31), rand_value(), 0, '0);
        2: issue_command(ACT_UNUSED, $urandom_range(0, 31), $urandom_range(0, 31),
                         $urandom, 0, '0);
        default: begin
          if (rows.size() == 0) begin
            r = $urandom_range(0, 31);
            c = $urandom_range(0, 31);
          end else begin
            r = rows[$urandom_range(0, rows.size() - 1)];
            c = cols[$urandom_range(0, cols.size() - 1)];
          end
          issue_command(ACT_READ, r, c, $urandom, 0, '0);
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    product_beat_t want;
    if (rst_n && out_valid) begin
      if (pending_products.size() == 0) begin
        note_mismatch($sformatf("unexpected result row %0d col %0d value %h",
                                out_row, out_col, out_product_value));
      end else begin
        want = pending_products.pop_front();
        if (out_row !== want.row)
          note_mismatch($sformatf("out_row: expected %0d actual %0d", want.row, out_row));
        if (out_col !== want.col)
          note_mismatch($sformatf("out_col: expected %0d actual %0d", want.col, out_col));
        if (out_product_value !== want.value)
          note_mismatch($sformatf("product (%0d,%0d): expected %h actual %h",
                                  want.row, want.col, want.value, out_product_value));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int phase;
    int base;
    logic [SIZE_W-1:0] next_size;
    clk             = 1'b0;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_matrix_size = SIZE_RESET;
    start           = 1'b0;
    in_action       = ACT_WRITE_A;
    in_row          = '0;
    in_col          = '0;
    in_value        = '0;
    active_size     = SIZE_RESET;
    mismatch_count  = 0;
    commands_sent   = 0;
    idle_cycles     = 0;
    steady_stream   = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == STIM_SIZE) begin
        drain_and_resize(directed_rows[i].value[SIZE_W-1:0]);
      end else begin
        issue_command(directed_rows[i].action, directed_rows[i].row, directed_rows[i].col,
                      directed_rows[i].value, directed_rows[i].fixed,
                      directed_rows[i].product);
      end
    end

    base  = commands_sent;
    phase = 0;
    while (commands_sent - base < RANDOM_ITEMS) begin
      case (phase)
        0: next_size = 6'd32;
        1: next_size = 6'd1;
        2: next_size = 6'd63;
        3: next_size = 6'd0;
        default: begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: next_size = $urandom_range(1, 6);
            6, 7, 8:          next_size = $urandom_range(7, 16);
            default:          next_size = $urandom_range(17, 32);
          endcase
        end
      endcase
      run_phase(next_size);
      phase++;
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_products.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== square_matrix_multiply.f =====
hw/rtl/sqmm_pkg.sv
hw/rtl/sqmm_front.sv
hw/rtl/sqmm_queue.sv
hw/rtl/sqmm_back.sv
hw/rtl/square_matrix_multiply.sv
tb/testbench.sv
